// ===== rtl/core/ssf_pkg.sv =====
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types and constants for the stick/slip friction proxy.
// ----------------------------------------------------------------------------
package ssf_pkg;

   localparam int FORCE_W = 24;
   localparam int COEF_W  = 16;
   localparam int PERIOD_W = 24;
   localparam int STEP_W  = 32;
   localparam int VEL_W   = 38;
   localparam int MAXM_W  = 36;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [COEF_W-1:0]   STATIC_COEF_RESET  = 16'd8192;
   localparam logic [COEF_W-1:0]   DYNAMIC_COEF_RESET = 16'd4096;
   localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RESET = 24'd16777;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STATIC_COEF  = 2'd0,
      CSR_DYNAMIC_COEF = 2'd1,
      CSR_FRAME_PERIOD = 2'd2
   } csr_index_type;

   // classified frame handed from front to back
   typedef struct packed {
      logic              slip;
      logic [VEL_W-1:0]  vel;
      logic [STEP_W-1:0] step_x;
      logic [STEP_W-1:0] step_y;
      logic              length_given;
      logic [STEP_W-1:0] step_length;
   } ssf_job_type;

endpackage

// ===== rtl/core/ssf_ifs.sv =====
// ----------------------------------------------------------------------------
// ssf channel interfaces
// Request, response and register write channels of the friction proxy.
// ----------------------------------------------------------------------------
interface ssf_req_if;
   import ssf_pkg::*;
   logic                valid;
   logic                ready;
   logic [FORCE_W-1:0]  tangent_force;
   logic [FORCE_W-1:0]  normal_force;
   logic signed [STEP_W-1:0] step_x;
   logic signed [STEP_W-1:0] step_y;
   logic                length_given;
   logic [STEP_W-1:0]   step_length;
   modport source (output valid, tangent_force, normal_force, step_x, step_y,
                   length_given, step_length, input ready);
   modport sink (input valid, tangent_force, normal_force, step_x, step_y,
                 length_given, step_length, output ready);
endinterface

interface ssf_rsp_if;
   import ssf_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [STEP_W-1:0] move_x;
   logic signed [STEP_W-1:0] move_y;
   logic                     sticking;
   modport source (output valid, move_x, move_y, sticking, input ready);
   modport sink (input valid, move_x, move_y, sticking, output ready);
endinterface

interface ssf_csr_if;
   import ssf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/stick_slip_proxy_friction.sv =====
// ----------------------------------------------------------------------------
// stick_slip_proxy_friction
// Coulomb stick/slip friction proxy: grants a proxy movement per frame.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  req_ch   in   forces, proposed step, optional step length
//  rsp_ch   out  granted movement and stick flag, one per request
//  csr_ch   in   register index and write data, always ready
//
//  a sticking frame goes straight to the response; a slipping frame finds
//  its movement limit, then the squares and serial square root (computed
//  length), then, when the step is scaled, the shared one-bit divider.
//  reset is synchronous; stick flag comes up set, registers at defaults.
//  a two-word queue lets the front take frames while the back stalls.
// ----------------------------------------------------------------------------
module stick_slip_proxy_friction import ssf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ssf_req_if.sink   req_ch,
   ssf_rsp_if.source rsp_ch,
   ssf_csr_if.sink   csr_ch
);

   logic [COEF_W-1:0]   static_coef_ff, dynamic_coef_ff;
   logic [PERIOD_W-1:0] frame_period_ff;
   logic                push, pop, q_ready, q_valid;
   ssf_job_type         wr_job, rd_job;

   assign csr_ch.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         static_coef_ff  <= STATIC_COEF_RESET;
         dynamic_coef_ff <= DYNAMIC_COEF_RESET;
         frame_period_ff <= FRAME_PERIOD_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_STATIC_COEF:  static_coef_ff  <= csr_ch.data[COEF_W-1:0];
            CSR_DYNAMIC_COEF: dynamic_coef_ff <= csr_ch.data[COEF_W-1:0];
            CSR_FRAME_PERIOD: frame_period_ff <= csr_ch.data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   ssf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .static_coef  (static_coef_ff),
      .dynamic_coef (dynamic_coef_ff),
      .push         (push),
      .job          (wr_job),
      .q_ready      (q_ready)
   );

   ssf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_job  (wr_job),
      .q_ready (q_ready),
      .pop     (pop),
      .q_valid (q_valid),
      .rd_job  (rd_job)
   );

   ssf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .frame_period (frame_period_ff),
      .q_valid      (q_valid),
      .q_job        (rd_job),
      .pop          (pop),
      .rsp          (rsp_ch)
   );

endmodule

// ===== rtl/core/ssf_front.sv =====
// ----------------------------------------------------------------------------
// ssf_front
// Takes a frame, updates the stick/slip flag and computes the slip velocity.
// ----------------------------------------------------------------------------
module ssf_front import ssf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   ssf_req_if.sink            req,
   input  logic [COEF_W-1:0]  static_coef,
   input  logic [COEF_W-1:0]  dynamic_coef,
   output logic               push,
   output ssf_job_type        job,
   input  logic               q_ready
);

   logic               hold_valid_ff;
   logic [FORCE_W-1:0] tf_ff, nf_ff;
   logic [STEP_W-1:0]  sx_ff, sy_ff, glen_ff;
   logic               given_ff;
   logic               stuck_ff;

   logic [VEL_W-1:0]   t26;
   logic [VEL_W+1:0]   stat_prod, dyn_prod;
   logic               still_stuck, slip;

   // force comparisons in Q.26
   always_comb begin
      t26         = {tf_ff, 14'd0};
      stat_prod   = static_coef * nf_ff;
      dyn_prod    = dynamic_coef * nf_ff;
      still_stuck = stuck_ff && !({2'd0, t26} > stat_prod);
      slip        = !still_stuck && ({2'd0, t26} > dyn_prod);
   end

   assign push      = hold_valid_ff && q_ready;
   assign req.ready = !hold_valid_ff || q_ready;

   always_comb begin
      job.slip         = slip;
      job.vel          = t26 - dyn_prod[VEL_W-1:0];
      job.step_x       = sx_ff;
      job.step_y       = sy_ff;
      job.length_given = given_ff;
      job.step_length  = glen_ff;
   end

   // input hold word and contact flag
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         stuck_ff      <= 1'b1;
      end else begin
         if (push) begin
            stuck_ff <= !slip;
         end
         if (req.valid && req.ready) begin
            hold_valid_ff <= 1'b1;
         end else if (push) begin
            hold_valid_ff <= 1'b0;
         end
      end
      if (req.valid && req.ready) begin
         tf_ff    <= req.tangent_force;
         nf_ff    <= req.normal_force;
         sx_ff    <= req.step_x;
         sy_ff    <= req.step_y;
         given_ff <= req.length_given;
         glen_ff  <= req.step_length;
      end
   end

endmodule

// ===== rtl/core/ssf_queue.sv =====
// ----------------------------------------------------------------------------
// ssf_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module ssf_queue import ssf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ssf_job_type wr_job,
   output logic        q_ready,
   input  logic        pop,
   output logic        q_valid,
   output ssf_job_type rd_job
);

   ssf_job_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign q_ready = (count_ff != 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign rd_job  = entry_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// ===== rtl/core/ssf_back.sv =====
// ----------------------------------------------------------------------------
// ssf_back
// Computes the movement limit, the step length and the scaled movement.
// ----------------------------------------------------------------------------
module ssf_back import ssf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [PERIOD_W-1:0] frame_period,
   input  logic                q_valid,
   input  ssf_job_type         q_job,
   output logic                pop,
   ssf_rsp_if.source           rsp
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_SQ_X, ST_SQ_Y, ST_ROOT, ST_CHECK,
      ST_MUL_X, ST_DIV_X, ST_MUL_Y, ST_DIV_Y, ST_DONE
   } state_type;

   state_type          state_ff;
   ssf_job_type        job_ff;
   logic [61:0]        acc_ff;
   logic [MAXM_W-1:0]  maxm_ff;
   logic [63:0]        rad_ff, res_ff, bit_ff;
   logic [STEP_W-1:0]  len_ff;
   logic [STEP_W-1:0]  rem_ff;
   logic [STEP_W-1:0]  quo_ff;
   logic [5:0]         cnt_ff;
   logic [STEP_W-1:0]  mx_ff, my_ff;
   logic               rsp_valid_ff;
   logic [STEP_W-1:0]  out_x_ff, out_y_ff;
   logic               out_stick_ff;

   logic [STEP_W-1:0]  mag_x, mag_y, len_sel;
   logic [63:0]        root_try;
   logic [STEP_W:0]    rem_sh;
   logic               rem_ge;

   function automatic logic [STEP_W-1:0] apply_sign(input logic neg,
                                                    input logic [STEP_W-1:0] q);
      logic [STEP_W-1:0] r;
      if (neg) begin
         r = (q > 32'h8000_0000) ? 32'h8000_0000 : q;
         return -r;
      end
      return (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
   endfunction

   // operand magnitudes, root trial and divider step
   always_comb begin
      mag_x    = job_ff.step_x[STEP_W-1] ? -job_ff.step_x : job_ff.step_x;
      mag_y    = job_ff.step_y[STEP_W-1] ? -job_ff.step_y : job_ff.step_y;
      len_sel  = job_ff.length_given ? job_ff.step_length : res_ff[STEP_W-1:0];
      root_try = res_ff + bit_ff;
      rem_sh   = {rem_ff, quo_ff[STEP_W-1]};
      rem_ge   = (rem_sh >= {1'b0, len_ff});
   end

   assign pop          = (state_ff == ST_IDLE) && q_valid;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.move_x   = out_x_ff;
   assign rsp.move_y   = out_y_ff;
   assign rsp.sticking = out_stick_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  job_ff <= q_job;
                  mx_ff  <= '0;
                  my_ff  <= '0;
                  state_ff <= q_job.slip ? ST_MUL_LO : ST_DONE;
               end
            end
            ST_MUL_LO: begin
               acc_ff   <= 62'(job_ff.vel[18:0]) * 62'(frame_period);
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               maxm_ff  <= 36'((acc_ff + ((62'(job_ff.vel[VEL_W-1:19])
                                            * 62'(frame_period)) << 19)) >> 26);
               state_ff <= job_ff.length_given ? ST_CHECK : ST_SQ_X;
               res_ff   <= '0;
            end
            ST_SQ_X: begin
               rad_ff   <= mag_x * mag_x;
               state_ff <= ST_SQ_Y;
            end
            ST_SQ_Y: begin
               rad_ff   <= rad_ff + mag_y * mag_y;
               res_ff   <= '0;
               bit_ff   <= 64'h4000_0000_0000_0000;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               // one result bit per cycle
               if (rad_ff >= root_try) begin
                  rad_ff <= rad_ff - root_try;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff == 64'd1) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               len_ff <= len_sel;
               if ({4'd0, len_sel} > maxm_ff) begin
                  state_ff <= ST_MUL_X;
               end else begin
                  mx_ff    <= job_ff.step_x;
                  my_ff    <= job_ff.step_y;
                  state_ff <= ST_DONE;
               end
            end
            ST_MUL_X, ST_MUL_Y: begin
               // quotient fits 32 bits since the limit is below the length
               {rem_ff, quo_ff} <= {32'd0, ((state_ff == ST_MUL_X) ? mag_x : mag_y)}
                                   * {32'd0, maxm_ff[STEP_W-1:0]};
               cnt_ff   <= 6'd32;
               state_ff <= (state_ff == ST_MUL_X) ? ST_DIV_X : ST_DIV_Y;
            end
            ST_DIV_X, ST_DIV_Y: begin
               rem_ff <= rem_ge ? 32'(rem_sh - {1'b0, len_ff}) : rem_sh[STEP_W-1:0];
               quo_ff <= {quo_ff[STEP_W-2:0], rem_ge};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  if (state_ff == ST_DIV_X) begin
                     mx_ff    <= apply_sign(job_ff.step_x[STEP_W-1],
                                            {quo_ff[STEP_W-2:0], rem_ge});
                     state_ff <= ST_MUL_Y;
                  end else begin
                     my_ff    <= apply_sign(job_ff.step_y[STEP_W-1],
                                            {quo_ff[STEP_W-2:0], rem_ge});
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  out_x_ff     <= mx_ff;
                  out_y_ff     <= my_ff;
                  out_stick_ff <= !job_ff.slip;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
